// File: hw/rtl/pff_pkg.sv
// ----------------------------------------------------------------------------
// pff_pkg
// Shared types, constants and helpers for the purple fringe pixel fix unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pff_pkg;

  // sample precision, 8..16 bits inside 16-bit fields
  localparam int unsigned PIXEL_BITS = 16;
  localparam int unsigned SAMPLE_W   = 16;

  localparam logic [SAMPLE_W-1:0] FULL_SCALE =
    SAMPLE_W'((32'd1 << PIXEL_BITS) - 32'd1);

  localparam int unsigned STRENGTH_W = 17;
  localparam int unsigned CFG_IDX_W  = 2;

  // blend divisor 114 done as reciprocal multiply, then one correction step
  localparam int unsigned DIV_SHIFT  = 32;
  localparam int unsigned DIV_IN_W   = 26;
  localparam int unsigned DIV_OUT_W  = 19;
  localparam logic [25:0] BLEND_DIV  = 26'd114;
  localparam logic [25:0] RECIP_114  = 26'((64'd1 << DIV_SHIFT) / 64'd114);

  // luminance weights, sum 65536
  localparam logic [31:0] LUMA_R = 32'd19595;
  localparam logic [31:0] LUMA_G = 32'd38470;
  localparam logic [31:0] LUMA_B = 32'd7471;

  // blend weights for blue and green
  localparam logic [41:0] BLEND_B = 42'd114;
  localparam logic [41:0] BLEND_G = 42'd587;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // results at or above FS * 2^PIXEL_BITS saturate
  localparam logic [35:0] SAT_LIMIT = 36'(FULL_SCALE) << PIXEL_BITS;
  localparam logic [35:0] LOW_MASK  = 36'(FULL_SCALE);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLUE_STRENGTH  = 2'd0,
    CFG_LUMA_THRESHOLD = 2'd1,
    CFG_USE_STAR_MASK  = 2'd2
  } pff_cfg_idx_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] red_in;
    logic [SAMPLE_W-1:0] green_in;
    logic [SAMPLE_W-1:0] blue_in;
    logic                mask_hit;
  } pff_req_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] blue_out;
    logic                was_changed;
  } pff_res_t;

  function automatic logic [SAMPLE_W-1:0] clamp_sample(input logic [SAMPLE_W-1:0] v);
    clamp_sample = (v > FULL_SCALE) ? FULL_SCALE : v;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pff_div114.sv
// ----------------------------------------------------------------------------
// pff_div114
// Two-stage pipelined floor division by 114: reciprocal multiply, then fixup.
// ----------------------------------------------------------------------------
`default_nettype none

module pff_div114 import pff_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic [DIV_IN_W-1:0]  dividend_i,
  output logic      [DIV_OUT_W-1:0] quotient_o
);

  logic [DIV_IN_W-1:0]     dividend_q;
  logic [2*DIV_IN_W-1:0]   prod_q;
  logic [DIV_OUT_W-1:0]    quot_q;

  logic [DIV_IN_W-DIV_SHIFT+DIV_IN_W-1:0] est;
  logic [DIV_IN_W-1:0]     rem;
  logic [DIV_OUT_W-1:0]    quot_d;

  // estimate is exact or one short, so one compare fixes it
  always_comb begin
    est    = prod_q[2*DIV_IN_W-1:DIV_SHIFT];
    rem    = dividend_q - DIV_IN_W'(est * BLEND_DIV);
    quot_d = DIV_OUT_W'(est) + DIV_OUT_W'(rem >= BLEND_DIV);
  end

  always_ff @(posedge clk_i) begin
    dividend_q <= dividend_i;
    prod_q     <= (2*DIV_IN_W)'(dividend_i) * (2*DIV_IN_W)'(RECIP_114);
    quot_q     <= quot_d;
  end

  assign quotient_o = quot_q;

endmodule

`default_nettype wire

// File: hw/rtl/purple_fringe_pixel_fix_unit.sv
// ----------------------------------------------------------------------------
// purple_fringe_pixel_fix_unit
// An accepted request passes through the registered stages to the done strobe.
// Throughput one pixel per cycle; busy_o stays low and the pipeline never stalls.
// Reset clears the pipeline valid bits and loads strength 1.0 (pass-through),
// threshold 0 and luminance qualification; the receiver cannot stall results.
// ----------------------------------------------------------------------------
`default_nettype none

module purple_fringe_pixel_fix_unit import pff_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire pff_req_t              req_i,
  output logic                       done_o,
  output pff_res_t                   res_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [STRENGTH_W-1:0] cfg_wdata_i
);

  localparam int unsigned LATENCY = 7;

  logic [STRENGTH_W-1:0] strength_q;
  logic [SAMPLE_W-1:0]   luma_thr_q;
  logic                  use_mask_q;

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strength_q <= ONE_Q16;
      luma_thr_q <= '0;
      use_mask_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BLUE_STRENGTH:  strength_q <= cfg_wdata_i;
        CFG_LUMA_THRESHOLD: luma_thr_q <= cfg_wdata_i[SAMPLE_W-1:0];
        CFG_USE_STAR_MASK:  use_mask_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // valid bits, one per stage
  logic [LATENCY-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LATENCY-2:0], accept};
    end
  end

  // ---------------- stage 1: hue numerator, luminance, blend products
  logic [SAMPLE_W-1:0] r_c, g_c, b_c, hi, lo, hue_d_d;
  logic signed [19:0]  n_s;
  logic [18:0]         hue_n_d;
  logic [31:0]         lum_d, p1_d;
  logic [32:0]         p2_d;
  logic [16:0]         inv_m;

  always_comb begin
    r_c = clamp_sample(req_i.red_in);
    g_c = clamp_sample(req_i.green_in);
    b_c = clamp_sample(req_i.blue_in);
    hi  = r_c;
    lo  = r_c;
    if (g_c > hi) hi = g_c;
    if (b_c > hi) hi = b_c;
    if (g_c < lo) lo = g_c;
    if (b_c < lo) lo = b_c;
    hue_d_d = hi - lo;
    if (r_c == hi) begin
      n_s = 20'(signed'({4'd0, g_c})) - 20'(signed'({4'd0, b_c}));
    end else if (g_c == hi) begin
      n_s = 20'(signed'({3'd0, hue_d_d, 1'b0})) + 20'(signed'({4'd0, b_c}))
            - 20'(signed'({4'd0, r_c}));
    end else begin
      n_s = 20'(signed'({2'd0, hue_d_d, 2'b0})) + 20'(signed'({4'd0, r_c}))
            - 20'(signed'({4'd0, g_c}));
    end
    if (n_s < 0) n_s = n_s + 20'(signed'({4'd0, hue_d_d})) * 20'sd6;
    hue_n_d = n_s[18:0];
    lum_d = LUMA_R * 32'(r_c) + LUMA_G * 32'(g_c) + LUMA_B * 32'(b_c);
    inv_m = ONE_Q16 - {1'b0, strength_q[15:0]};
    p1_d  = 32'(b_c) * 32'(strength_q[15:0]);
    p2_d  = 33'(g_c) * 33'(inv_m);
  end

  logic [SAMPLE_W-1:0] s1_b_q, s1_g_q, s1_hue_d_q;
  logic [18:0]         s1_hue_n_q;
  logic [31:0]         s1_lum_q, s1_p1_q;
  logic [32:0]         s1_p2_q;
  logic                s1_mask_q;

  always_ff @(posedge clk_i) begin
    s1_b_q     <= b_c;
    s1_g_q     <= g_c;
    s1_hue_d_q <= hue_d_d;
    s1_hue_n_q <= hue_n_d;
    s1_lum_q   <= lum_d;
    s1_p1_q    <= p1_d;
    s1_p2_q    <= p2_d;
    s1_mask_q  <= req_i.mask_hit;
  end

  // ---------------- stage 2: purple test, qualification, blend sum
  logic        purple, qual, chg_d;
  logic [41:0] blend_sum;

  always_comb begin
    purple = (s1_hue_d_q != '0)
           && (22'(s1_hue_n_q) * 22'd5 >= 22'(s1_hue_d_q) * 22'd12)
           && (26'(s1_hue_n_q) * 26'd100 <= 26'(s1_hue_d_q) * 26'd594);
    qual   = use_mask_q ? s1_mask_q : (s1_lum_q > {luma_thr_q, 16'h0000});
    chg_d  = ~strength_q[16] & purple & qual;
    blend_sum = BLEND_B * 42'(s1_p1_q) + BLEND_G * 42'(s1_p2_q);
  end

  logic [SAMPLE_W-1:0] s2_b_q, s2_g_q;
  logic                s2_chg_q;
  logic [DIV_IN_W-1:0] s2_y_q;

  always_ff @(posedge clk_i) begin
    s2_b_q   <= s1_b_q;
    s2_g_q   <= s1_g_q;
    s2_chg_q <= chg_d;
    s2_y_q   <= blend_sum[41:16];
  end

  // ---------------- stages 3 and 4: divide by 114
  logic [DIV_OUT_W-1:0] b1;

  pff_div114 u_div (
    .clk_i      (clk_i),
    .dividend_i (s2_y_q),
    .quotient_o (b1)
  );

  logic [SAMPLE_W-1:0] s3_b_q, s3_g_q, s4_b_q, s4_g_q;
  logic                s3_chg_q, s4_chg_q;

  always_ff @(posedge clk_i) begin
    s3_b_q   <= s2_b_q;
    s3_g_q   <= s2_g_q;
    s3_chg_q <= s2_chg_q;
    s4_b_q   <= s3_b_q;
    s4_g_q   <= s3_g_q;
    s4_chg_q <= s3_chg_q;
  end

  // ---------------- stage 5: times strength
  logic [SAMPLE_W-1:0] s5_b_q, s5_g_q;
  logic                s5_chg_q;
  logic [34:0]         s5_t_q;

  always_ff @(posedge clk_i) begin
    s5_b_q   <= s4_b_q;
    s5_g_q   <= s4_g_q;
    s5_chg_q <= s4_chg_q;
    s5_t_q   <= 35'(b1) * 35'(strength_q[15:0]);
  end

  // ---------------- stage 6: times (green + full scale)
  logic [SAMPLE_W-1:0] s6_b_q;
  logic                s6_chg_q;
  logic [51:0]         s6_u_q;

  always_ff @(posedge clk_i) begin
    s6_b_q   <= s5_b_q;
    s6_chg_q <= s5_chg_q;
    s6_u_q   <= 52'(s5_t_q) * 52'(17'(s5_g_q) + 17'(FULL_SCALE));
  end

  // ---------------- stage 7: divide by 65536 * FS, saturate, output register
  logic [35:0]         v, q0, rem7;
  logic [SAMPLE_W-1:0] b2;
  pff_res_t            res_d;

  always_comb begin
    v    = s6_u_q[51:16];
    // 2^P - 1 divisor: shift estimate is exact or one short
    q0   = v >> PIXEL_BITS;
    rem7 = (v & LOW_MASK) + q0;
    if (v >= SAT_LIMIT) begin
      b2 = FULL_SCALE;
    end else begin
      b2 = q0[SAMPLE_W-1:0] + SAMPLE_W'(rem7 >= 36'(FULL_SCALE));
    end
    res_d.blue_out    = s6_chg_q ? b2 : s6_b_q;
    res_d.was_changed = s6_chg_q;
  end

  pff_res_t res_q;
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = vld_q[LATENCY-1];
  assign res_o  = res_q;

  // ---------------- checks
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##7 done_o) else $error("request produced no result");

  a_done_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 7)) else $error("result without request");

  a_pass_blue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.was_changed)
      |-> res_o.blue_out == clamp_sample($past(req_i.blue_in, 7)))
    else $error("unchanged pixel lost its blue value");

endmodule

`default_nettype wire
